### rtl/srr_pkg.sv
// ----------------------------------------------------------------------------
// srr_pkg: shared definitions for the selective-repeat receiver
// Register indexes, field widths, result codes and the cell control bundle.
// ----------------------------------------------------------------------------
package srr_pkg;

  // default sizing handed to the top level
  localparam int WINDOW_SLOTS_DEF = 8;
  localparam int SEQ_BITS_DEF     = 8;

  // fixed field widths
  localparam int SEQ_W     = 8;
  localparam int PAYLOAD_W = 64;
  localparam int ACK_W     = 8;

  // configuration port
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 9;
  localparam int CFG_MOD_W  = 9;
  localparam int CFG_WIN_W  = 4;

  localparam logic [CFG_IDX_W-1:0] REG_SEQ_MODULUS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_RX_WIN      = CFG_IDX_W'(1);

  localparam logic [CFG_MOD_W-1:0] SEQ_MODULUS_RST = CFG_MOD_W'(8);
  localparam logic [CFG_WIN_W-1:0] RX_WIN_RST      = CFG_WIN_W'(4);

  // result type codes
  localparam logic RT_DELIVER = 1'b0;
  localparam logic RT_ACK     = 1'b1;

  // control shared by every cell of the slot chain
  typedef struct packed {
    logic clear;
    logic shift;
    logic load;
  } cell_ctrl_t;

endpackage

### rtl/srr_cell.sv
// ----------------------------------------------------------------------------
// srr_cell: one receive slot of the slot chain
// Holds a valid bit and a payload word; loads a new packet when selected and
// takes its upper neighbor's contents when the chain shifts down.
// ----------------------------------------------------------------------------
module srr_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  srr_pkg::cell_ctrl_t           ctrl_i,
  input  logic                          sel_i,
  input  logic [srr_pkg::PAYLOAD_W-1:0] pay_i,
  input  logic                          next_valid_i,
  input  logic [srr_pkg::PAYLOAD_W-1:0] next_pay_i,
  output logic                          valid_o,
  output logic [srr_pkg::PAYLOAD_W-1:0] pay_o
);

  logic                          valid_q, valid_d;
  logic [srr_pkg::PAYLOAD_W-1:0] pay_q, pay_d;

  // next contents of the slot
  always_comb begin
    valid_d = valid_q;
    pay_d   = pay_q;
    if (ctrl_i.clear) begin
      valid_d = 1'b0;
    end else if (ctrl_i.shift) begin
      valid_d = next_valid_i;
      pay_d   = next_pay_i;
    end else if (ctrl_i.load && sel_i) begin
      valid_d = 1'b1;
      pay_d   = pay_i;
    end
  end

  // valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload word
  always_ff @(posedge clk_i) begin
    pay_q <= pay_d;
  end

  assign valid_o = valid_q;
  assign pay_o   = pay_q;

endmodule

### rtl/selective_repeat_receiver.sv
// ----------------------------------------------------------------------------
// selective_repeat_receiver: selective-repeat receive side
// Buffers in-window packets in a chain of slot cells, delivers them in order
// and acknowledges every packet with a good checksum with the receive base.
// ----------------------------------------------------------------------------
// A packet with a bad checksum is taken and gives nothing. A duplicate or
// out-of-window packet gives one acknowledgement. A new in-window packet is
// written into its slot, then the chain of slot cells is scanned from the
// base, one slot per cycle, to find the run of k filled slots; the run is
// then shifted out of cell 0, one delivery per cycle while the output is not
// held by backpressure, and an acknowledgement closes it. The output
// register lets the next packet be taken while the closing acknowledgement
// still waits. Every result carries the receive base after the whole
// packet. A configuration write restarts the receiver: the base goes to
// zero and all slots empty.
module selective_repeat_receiver #(
  parameter int WINDOW_SLOTS = srr_pkg::WINDOW_SLOTS_DEF,
  parameter int SEQ_BITS     = srr_pkg::SEQ_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // packet request
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [71:0]                    s_axis_tdata,  // seq_num[7:0], payload[71:8]
  input  logic                           s_axis_tuser,  // checksum_ok
  // result request
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [71:0]                    m_axis_tdata,  // data_out[63:0], ack_num[71:64]
  output logic                           m_axis_tuser,  // result_type
  output logic                           m_axis_tlast,  // last
  // configuration write
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [srr_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [srr_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  localparam int PW   = srr_pkg::PAYLOAD_W;
  localparam int WW   = (SEQ_BITS + 1 > srr_pkg::CFG_MOD_W) ? SEQ_BITS + 1 : srr_pkg::CFG_MOD_W;
  localparam int IDXW = (WINDOW_SLOTS > 1) ? $clog2(WINDOW_SLOTS) : 1;
  localparam int CNTW = $clog2(WINDOW_SLOTS + 1);

  localparam logic [WW-1:0]   MOD_TOP  = WW'(1) << SEQ_BITS;
  localparam logic [WW-1:0]   MOD_MIN  = WW'(2);
  localparam logic [WW-1:0]   SLOTS_WW = WW'(WINDOW_SLOTS);
  localparam logic [CNTW-1:0] SLOTS_CN = CNTW'(WINDOW_SLOTS);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_DELIV = 2'd2;
  localparam logic [1:0] ST_ACK   = 2'd3;

  logic [1:0]                     state_q, state_d;
  logic [CNTW-1:0]                cnt_q, cnt_d;
  logic [SEQ_BITS-1:0]            base_q, base_d;
  logic [srr_pkg::CFG_MOD_W-1:0]  seq_modulus_q;
  logic [srr_pkg::CFG_WIN_W-1:0]  rx_win_q;

  logic                           out_valid_q;
  logic                           out_type_q;
  logic [PW-1:0]                  out_data_q;
  logic [srr_pkg::ACK_W-1:0]      out_ack_q;
  logic                           out_last_q;
  logic                           out_free;
  logic                           out_load;
  logic                           out_type_d;
  logic [PW-1:0]                  out_data_d;
  logic                           out_last_d;

  logic                           in_accept;
  logic                           cfg_write;
  logic [srr_pkg::SEQ_W-1:0]      in_seq;
  logic [PW-1:0]                  in_pay;

  logic [WW-1:0]                  mod_raw, mod_eff, win_half, win_eff;
  logic [WW-1:0]                  seq_w, base_w, off, base_sum;
  logic                           valid_at_off, in_window, valid_at_cnt;

  srr_pkg::cell_ctrl_t            ctrl;
  logic [WINDOW_SLOTS-1:0]        cell_valid;
  logic [PW-1:0]                  cell_pay [WINDOW_SLOTS];

  assign in_seq      = s_axis_tdata[srr_pkg::SEQ_W-1:0];
  assign in_pay      = s_axis_tdata[srr_pkg::SEQ_W +: PW];
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_accept   = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o = 1'b1;
  assign cfg_write   = cfg_valid_i && ((cfg_index_i == srr_pkg::REG_SEQ_MODULUS) ||
                                       (cfg_index_i == srr_pkg::REG_RX_WIN));

  // effective modulus and window from the registers
  always_comb begin
    mod_raw = WW'(seq_modulus_q);
    if (mod_raw < MOD_MIN) begin
      mod_eff = MOD_MIN;
    end else if (mod_raw > MOD_TOP) begin
      mod_eff = MOD_TOP;
    end else begin
      mod_eff = mod_raw;
    end
    win_half = mod_eff >> 1;
    win_eff  = WW'(rx_win_q);
    if (win_eff > SLOTS_WW) begin
      win_eff = SLOTS_WW;
    end
    if (win_eff > win_half) begin
      win_eff = win_half;
    end
    if (win_eff == '0) begin
      win_eff = WW'(1);
    end
  end

  // slot offset of the arriving packet and window check
  assign seq_w  = WW'(in_seq);
  assign base_w = WW'(base_q);
  assign off    = (seq_w >= base_w) ? (seq_w - base_w) : (seq_w + mod_eff - base_w);
  assign valid_at_off = (off < SLOTS_WW) ? cell_valid[off[IDXW-1:0]] : 1'b1;
  assign in_window = s_axis_tuser && (seq_w < mod_eff) && (off < win_eff) && !valid_at_off;

  // scan probe and base after the filled run
  assign valid_at_cnt = (cnt_q < SLOTS_CN) ? cell_valid[cnt_q[IDXW-1:0]] : 1'b0;
  always_comb begin
    base_sum = base_w + WW'(cnt_q);
    if (base_sum >= mod_eff) begin
      base_sum = base_sum - mod_eff;
    end
  end

  assign out_free = !out_valid_q || m_axis_tready;

  // sequencer
  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    base_d     = base_q;
    ctrl       = '0;
    out_load   = 1'b0;
    out_type_d = srr_pkg::RT_ACK;
    out_data_d = '0;
    out_last_d = 1'b1;
    case (state_q)
      ST_IDLE: begin
        if (in_accept && s_axis_tuser) begin
          if (in_window) begin
            ctrl.load = 1'b1;
            cnt_d     = '0;
            state_d   = ST_SCAN;
          end else begin
            state_d = ST_ACK;
          end
        end
      end
      ST_SCAN: begin
        if (valid_at_cnt) begin
          cnt_d = cnt_q + CNTW'(1);
        end else begin
          base_d  = base_sum[SEQ_BITS-1:0];
          state_d = (cnt_q == '0) ? ST_ACK : ST_DELIV;
        end
      end
      ST_DELIV: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_type_d = srr_pkg::RT_DELIVER;
          out_data_d = cell_pay[0];
          out_last_d = 1'b0;
          ctrl.shift = 1'b1;
          cnt_d      = cnt_q - CNTW'(1);
          if (cnt_q == CNTW'(1)) begin
            state_d = ST_ACK;
          end
        end
      end
      ST_ACK: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    // a register write restarts the receiver
    if (cfg_write) begin
      ctrl.clear = 1'b1;
      base_d     = '0;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      cnt_q         <= '0;
      base_q        <= '0;
      seq_modulus_q <= srr_pkg::SEQ_MODULUS_RST;
      rx_win_q      <= srr_pkg::RX_WIN_RST;
      out_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      base_q  <= base_d;
      if (cfg_valid_i && (cfg_index_i == srr_pkg::REG_SEQ_MODULUS)) begin
        seq_modulus_q <= cfg_data_i[srr_pkg::CFG_MOD_W-1:0];
      end
      if (cfg_valid_i && (cfg_index_i == srr_pkg::REG_RX_WIN)) begin
        rx_win_q <= cfg_data_i[srr_pkg::CFG_WIN_W-1:0];
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // output payload register
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_type_q <= out_type_d;
      out_data_q <= out_data_d;
      out_ack_q  <= srr_pkg::ACK_W'(base_q);
      out_last_q <= out_last_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_ack_q, out_data_q};
  assign m_axis_tuser  = out_type_q;
  assign m_axis_tlast  = out_last_q;

  // chain of slot cells, slot i holds sequence base + i
  for (genvar i = 0; i < WINDOW_SLOTS; i++) begin : g_slot
    logic          next_valid;
    logic [PW-1:0] next_pay;
    logic          sel;

    if (i + 1 < WINDOW_SLOTS) begin : g_mid
      assign next_valid = cell_valid[i+1];
      assign next_pay   = cell_pay[i+1];
    end else begin : g_top
      assign next_valid = 1'b0;
      assign next_pay   = '0;
    end

    assign sel = (off[IDXW-1:0] == IDXW'(i));

    srr_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .sel_i        (sel),
      .pay_i        (in_pay),
      .next_valid_i (next_valid),
      .next_pay_i   (next_pay),
      .valid_o      (cell_valid[i]),
      .pay_o        (cell_pay[i])
    );
  end

endmodule
